// ===== rtl/plm_pkg.sv =====
// Package for the parameter limit monitor: table size, command and status
// codes, and the packed types for the request word, table entry and result word.
// No dependencies.
package plm_pkg;

   // Table size and entry address width
   localparam int NUM_ENTRIES = 64;
   localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   // Field widths
   localparam int CMD_W   = 2;
   localparam int INDEX_W = 16;
   localparam int IVL_W   = 16;
   localparam int LIMIT_W = 64;
   localparam int EVID_W  = 16;
   localparam int ST_W    = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEFINE  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd3;

   // Monitor status codes
   localparam logic [ST_W-1:0] ST_UNSELECTED = 2'd0;
   localparam logic [ST_W-1:0] ST_UNCHECKED  = 2'd1;
   localparam logic [ST_W-1:0] ST_VALID      = 2'd2;
   localparam logic [ST_W-1:0] ST_INVALID    = 2'd3;

   // One request word
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] index;
      logic [IVL_W-1:0]   interval;
      logic [LIMIT_W-1:0] low_limit;
      logic [EVID_W-1:0]  low_event_id;
      logic [LIMIT_W-1:0] high_limit;
      logic [EVID_W-1:0]  high_event_id;
      logic [LIMIT_W-1:0] sample;
   } req_type;

   // One table entry
   typedef struct packed {
      logic               enabled;
      logic [IVL_W-1:0]   interval;
      logic [IVL_W-1:0]   counter;
      logic [ST_W-1:0]    status;
      logic [ST_W-1:0]    prior;
      logic [LIMIT_W-1:0] low_limit;
      logic [LIMIT_W-1:0] high_limit;
      logic [EVID_W-1:0]  low_event_id;
      logic [EVID_W-1:0]  high_event_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // One result word
   typedef struct packed {
      logic              accepted;
      logic              event_valid;
      logic [EVID_W-1:0] event_id;
      logic [ST_W-1:0]   entry_status;
      logic [ST_W-1:0]   prior_status;
   } rsp_type;

   // Contents of an entry that was never written since reset
   function automatic entry_type entry_reset();
      entry_type e;
      e          = '0;
      e.interval = IVL_W'(1);
      e.status   = ST_UNSELECTED;
      e.prior    = ST_UNSELECTED;
      return e;
   endfunction

endpackage

// ===== rtl/plm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module plm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/plm_update.sv =====
// Entry update logic: applies one command word to the current table entry and
// forms the next entry and the result word. Depends on plm_pkg.
module plm_update
   import plm_pkg::*;
(
   input  req_type   req,
   input  entry_type cur,
   output entry_type nxt,
   output logic      wr_en,
   output rsp_type   rsp
);

   logic              in_range;
   logic              ev;
   logic [EVID_W-1:0] eid;
   logic              above_high;
   logic              below_low;
   logic              strictly_in;

   assign in_range    = (req.index < INDEX_W'(NUM_ENTRIES));
   assign above_high  = (req.sample > cur.high_limit);
   assign below_low   = (req.sample < cur.low_limit);
   assign strictly_in = (req.sample < cur.high_limit) && (req.sample > cur.low_limit);

   // next entry contents and event
   always_comb begin
      nxt = cur;
      ev  = 1'b0;
      eid = '0;
      case (req.cmd)
         CMD_ENABLE: begin
            nxt.enabled = 1'b1;
            nxt.counter = '0;
            nxt.status  = ST_UNCHECKED;
         end
         CMD_DISABLE: begin
            nxt.enabled = 1'b0;
         end
         CMD_DEFINE: begin
            nxt.interval      = req.interval;
            nxt.counter       = '0;
            nxt.status        = ST_UNCHECKED;
            nxt.low_limit     = req.low_limit;
            nxt.high_limit    = req.high_limit;
            nxt.low_event_id  = req.low_event_id;
            nxt.high_event_id = req.high_event_id;
         end
         CMD_CHECK: begin
            if (cur.enabled) begin
               if (cur.counter < cur.interval) begin
                  nxt.counter = IVL_W'(cur.counter + IVL_W'(1));
               end else begin
                  nxt.counter = '0;
                  case (cur.status)
                     ST_UNSELECTED: begin
                     end
                     ST_INVALID: begin
                        // recovery needs a value strictly between the limits
                        if (strictly_in) begin
                           nxt.prior  = cur.status;
                           nxt.status = ST_VALID;
                        end
                     end
                     default: begin
                        // unchecked or valid; the high test wins
                        if (above_high) begin
                           ev         = 1'b1;
                           eid        = cur.high_event_id;
                           nxt.prior  = cur.status;
                           nxt.status = ST_INVALID;
                        end else if (below_low) begin
                           ev         = 1'b1;
                           eid        = cur.low_event_id;
                           nxt.prior  = cur.status;
                           nxt.status = ST_INVALID;
                        end else if (cur.status == ST_UNCHECKED) begin
                           nxt.prior  = cur.status;
                           nxt.status = ST_VALID;
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // result word; a bad index gives all zeros and no write
   always_comb begin
      wr_en = in_range;
      if (in_range) begin
         rsp.accepted     = 1'b1;
         rsp.event_valid  = ev;
         rsp.event_id     = eid;
         rsp.entry_status = nxt.status;
         rsp.prior_status = nxt.prior;
      end else begin
         rsp = '0;
      end
   end

endmodule

// ===== rtl/parameter_limit_monitor.sv =====
// Parameter limit monitor, top level: stream ports, entry table, entry
// written flags and the result register. Depends on plm_pkg, plm_ram, plm_update.
//
// Usage: every request word gives exactly one result word. A word accepted at
// one edge has its table entry read at that edge; the entry is updated and the
// result registered at the edge on which stage 1 moves on to the result
// register, which waits while a held result is not taken. One word is accepted
// every cycle while the result side takes words. The rate is set by the single
// table RAM: one read per word, then one write-back, with the write of one word
// forwarded to the next word when both name the same entry. Entries never
// written since reset read as their reset contents through a flag per entry,
// so no clearing pass follows reset.
module parameter_limit_monitor
   import plm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // [15:0] index, [31:16] interval, [95:32] low_limit, [111:96] low_event_id,
   // [175:112] high_limit, [191:176] high_event_id, [255:192] sample
   input  logic [255:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]   req_tuser,
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] accepted, [1] event_valid, [17:2] event_id, [19:18] entry_status,
   // [21:20] prior_status, [23:22] zero
   output logic [23:0]  rsp_tdata
);

   req_type          req_in;
   logic             req_accept;
   logic             advance;
   logic [IDX_W-1:0] rd_addr;

   logic             s1_valid_ff;
   req_type          s1_req_ff;
   logic             s1_written_ff;
   logic             s1_fwd_ff;
   entry_type        s1_fwd_entry_ff;

   logic [NUM_ENTRIES-1:0] written_ff;
   logic [NUM_ENTRIES-1:0] written_in;

   logic [ENTRY_W-1:0] ram_rdata;
   entry_type          cur;
   entry_type          nxt;
   logic               upd_wr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   rsp_type            upd_rsp;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // unpack the request word
   assign req_in.cmd           = req_tuser;
   assign req_in.index         = req_tdata[15:0];
   assign req_in.interval      = req_tdata[31:16];
   assign req_in.low_limit     = req_tdata[95:32];
   assign req_in.low_event_id  = req_tdata[111:96];
   assign req_in.high_limit    = req_tdata[175:112];
   assign req_in.high_event_id = req_tdata[191:176];
   assign req_in.sample        = req_tdata[255:192];

   // whole pipe moves when the result register is free or being emptied
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign req_accept = req_tvalid && advance;
   assign rd_addr    = req_in.index[IDX_W-1:0];

   // write-back of the word in stage 1
   assign wr_en   = s1_valid_ff && advance && upd_wr;
   assign wr_addr = s1_req_ff.index[IDX_W-1:0];

   plm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (nxt),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   // stage 1 payload, written flag and forward of a same-entry write
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff       <= req_in;
         s1_written_ff   <= written_ff[rd_addr];
         s1_fwd_ff       <= wr_en && (wr_addr == rd_addr);
         s1_fwd_entry_ff <= nxt;
      end
   end

   // per-entry written flags
   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   // current entry: forwarded, stored, or reset contents
   always_comb begin
      if (s1_fwd_ff) begin
         cur = s1_fwd_entry_ff;
      end else if (s1_written_ff) begin
         cur = entry_type'(ram_rdata);
      end else begin
         cur = entry_reset();
      end
   end

   plm_update u_update (
      .req   (s1_req_ff),
      .cur   (cur),
      .nxt   (nxt),
      .wr_en (upd_wr),
      .rsp   (upd_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.prior_status, rsp_ff.entry_status,
                        rsp_ff.event_id, rsp_ff.event_valid, rsp_ff.accepted};

endmodule

// ===== test/limit_monitor_checker.sv =====
// Result checker for the parameter limit monitor: watches both stream ports,
// keeps its own copy of the limit table and compares every result word.
// Depends on plm_pkg.
module limit_monitor_checker
   import plm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // [15:0] index, [31:16] interval, [95:32] low_limit, [111:96] low_event_id,
   // [175:112] high_limit, [191:176] high_event_id, [255:192] sample
   input  logic [255:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] accepted, [1] event_valid, [17:2] event_id, [19:18] entry_status,
   // [21:20] prior_status, [23:22] zero
   input  logic [23:0]  rsp_tdata,
   output int           fail_count,
   output int           outstanding
);

   typedef struct {
      bit               enabled;
      bit [IVL_W-1:0]   interval;
      bit [IVL_W-1:0]   counter;
      bit [ST_W-1:0]    status;
      bit [ST_W-1:0]    prior;
      bit [LIMIT_W-1:0] low_limit;
      bit [LIMIT_W-1:0] high_limit;
      bit [EVID_W-1:0]  low_id;
      bit [EVID_W-1:0]  high_id;
   } monitor_entry;

   typedef struct packed {
      bit              accepted;
      bit              event_valid;
      bit [EVID_W-1:0] event_id;
      bit [ST_W-1:0]   entry_status;
      bit [ST_W-1:0]   prior_status;
   } report_word;

   monitor_entry monitor_table [NUM_ENTRIES];
   report_word   pending_reports [$];
   report_word   want;
   report_word   got;
   int           errors       = 0;
   int           results_seen = 0;

   function automatic void report_miss(string field, longint unsigned want_v,
                                       longint unsigned got_v);
      if (errors < 10)
         $display("result %0d, %s: expected %0h, got %0h", results_seen, field,
                  want_v, got_v);
      errors++;
   endfunction

   // status change keeps the old status as prior
   function automatic void move_status(int e, bit [ST_W-1:0] st);
      monitor_table[e].prior  = monitor_table[e].status;
      monitor_table[e].status = st;
   endfunction

   // Apply one request word to the table and return the result it gives
   function automatic report_word apply_limit_word(input logic [CMD_W-1:0] cmd,
                                                   input logic [255:0] data);
      report_word       r;
      int               e;
      bit [LIMIT_W-1:0] v;
      r = '0;
      v = data[255:192];
      // bad index: all-zero result, table untouched
      if (data[15:0] >= NUM_ENTRIES)
         return r;
      e = int'(data[15:0]);
      case (cmd)
         CMD_ENABLE: begin
            monitor_table[e].enabled = 1'b1;
            monitor_table[e].counter = '0;
            monitor_table[e].status  = ST_UNCHECKED;
         end
         CMD_DISABLE: begin
            monitor_table[e].enabled = 1'b0;
         end
         CMD_DEFINE: begin
            monitor_table[e].interval   = data[31:16];
            monitor_table[e].counter    = '0;
            monitor_table[e].status     = ST_UNCHECKED;
            monitor_table[e].low_limit  = data[95:32];
            monitor_table[e].low_id     = data[111:96];
            monitor_table[e].high_limit = data[175:112];
            monitor_table[e].high_id    = data[191:176];
         end
         CMD_CHECK: begin
            if (!monitor_table[e].enabled) begin
               // disabled entry: no change
            end else if (monitor_table[e].counter < monitor_table[e].interval) begin
               monitor_table[e].counter++;
            end else begin
               monitor_table[e].counter = '0;
               if (monitor_table[e].status == ST_UNSELECTED) begin
                  // nothing to compare against
               end else if (monitor_table[e].status != ST_INVALID) begin
                  // high test first, so it wins on inverted limits
                  if (v > monitor_table[e].high_limit) begin
                     r.event_valid = 1'b1;
                     r.event_id    = monitor_table[e].high_id;
                     move_status(e, ST_INVALID);
                  end else if (v < monitor_table[e].low_limit) begin
                     r.event_valid = 1'b1;
                     r.event_id    = monitor_table[e].low_id;
                     move_status(e, ST_INVALID);
                  end else if (monitor_table[e].status == ST_UNCHECKED) begin
                     move_status(e, ST_VALID);
                  end
               end else if (v < monitor_table[e].high_limit &&
                            v > monitor_table[e].low_limit) begin
                  // leaving invalid needs a value strictly inside
                  move_status(e, ST_VALID);
               end
            end
         end
         default: begin
         end
      endcase
      r.accepted     = 1'b1;
      r.entry_status = monitor_table[e].status;
      r.prior_status = monitor_table[e].prior;
      return r;
   endfunction

   // Result words are checked before the request of the same edge is applied
   always @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < NUM_ENTRIES; e++) begin
            monitor_table[e].enabled    = 1'b0;
            monitor_table[e].interval   = IVL_W'(1);
            monitor_table[e].counter    = '0;
            monitor_table[e].status     = ST_UNSELECTED;
            monitor_table[e].prior      = ST_UNSELECTED;
            monitor_table[e].low_limit  = '0;
            monitor_table[e].high_limit = '0;
            monitor_table[e].low_id     = '0;
            monitor_table[e].high_id    = '0;
         end
         pending_reports.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.accepted     = rsp_tdata[0];
            got.event_valid  = rsp_tdata[1];
            got.event_id     = rsp_tdata[17:2];
            got.entry_status = rsp_tdata[19:18];
            got.prior_status = rsp_tdata[21:20];
            if (pending_reports.size() == 0) begin
               report_miss("word with nothing pending", 0, rsp_tdata);
            end else begin
               want = pending_reports.pop_front();
               if (got.accepted != want.accepted)
                  report_miss("accepted", want.accepted, got.accepted);
               if (got.event_valid != want.event_valid)
                  report_miss("event_valid", want.event_valid, got.event_valid);
               if (got.event_id != want.event_id)
                  report_miss("event_id", want.event_id, got.event_id);
               if (got.entry_status != want.entry_status)
                  report_miss("entry_status", want.entry_status, got.entry_status);
               if (got.prior_status != want.prior_status)
                  report_miss("prior_status", want.prior_status, got.prior_status);
            end
            results_seen++;
         end
         if (req_tvalid && req_tready)
            pending_reports.push_back(apply_limit_word(req_tuser, req_tdata));
      end
      fail_count  <= errors;
      outstanding <= pending_reports.size();
   end

endmodule

// ===== test/tb_parameter_limit_monitor.sv =====
// Testbench top for the parameter limit monitor: clock, reset, request and
// result stream drivers, watchdog and verdict. Depends on plm_pkg,
// limit_monitor_checker and the block itself.
module tb_parameter_limit_monitor;
   import plm_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int TARGET_WORDS = 800;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;
   int           fail_count;
   int           outstanding;

   // set for stretches with no idling on either side
   bit           no_idle    = 1'b0;
   int           words_sent = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   parameter_limit_monitor i_dut (.*);

   limit_monitor_checker i_checker (.*);

   function automatic int idle_cycles();
      return no_idle ? 0 : $urandom_range(0, 14);
   endfunction

   // request word with every field random
   function automatic req_type random_word();
      bit [319:0] bits;
      for (int k = 0; k < 10; k++)
         bits[k*32 +: 32] = $urandom;
      return req_type'(bits[$bits(req_type)-1:0]);
   endfunction

   // Drive one request word after a random gap and wait for its handshake
   task automatic send_word(input req_type w);
      int gap;
      gap = idle_cycles();
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.cmd;
      req_tdata  <= {w.sample, w.high_event_id, w.high_limit, w.low_event_id,
                     w.low_limit, w.interval, w.index};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_command(input logic [CMD_W-1:0] cmd, input int unsigned idx);
      req_type w;
      w       = random_word();
      w.cmd   = cmd;
      w.index = 16'(idx);
      send_word(w);
   endtask

   task automatic check_value(input int unsigned idx, input logic [63:0] value);
      req_type w;
      w        = random_word();
      w.cmd    = CMD_CHECK;
      w.index  = 16'(idx);
      w.sample = value;
      send_word(w);
   endtask

   task automatic define_entry(input int unsigned idx, input logic [15:0] ivl,
                               input logic [63:0] lo, input logic [63:0] hi);
      req_type w;
      w            = random_word();
      w.cmd        = CMD_DEFINE;
      w.index      = 16'(idx);
      w.interval   = ivl;
      w.low_limit  = lo;
      w.high_limit = hi;
      send_word(w);
   endtask

   // hold requests until every pending result is out
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Result side: random stall before each word
   initial begin
      int gap;
      forever begin
         gap = idle_cycles();
         @(negedge clock);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog: too long without any handshake ends the run
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL parameter_limit_monitor");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      req_type     w;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] span;
      logic [63:0] v;
      logic [15:0] ivl;
      int unsigned idx;
      int          next_drain;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // check on a disabled entry, then reset limits of zero
      check_value(0, 64'd5);
      send_command(CMD_ENABLE, 0);
      check_value(0, 64'd0);
      check_value(0, 64'd0);
      check_value(0, 64'd1);

      // every command on bad indexes
      send_command(CMD_CHECK, NUM_ENTRIES);
      send_command(CMD_ENABLE, 'hFFFF);
      send_command(CMD_DEFINE, NUM_ENTRIES);
      send_command(CMD_DISABLE, 'h8000);

      // last entry, zero interval: out, in, on the limits, and back
      define_entry(NUM_ENTRIES - 1, 16'd0, 64'd100, 64'd200);
      send_command(CMD_ENABLE, NUM_ENTRIES - 1);
      check_value(NUM_ENTRIES - 1, 64'd250);
      check_value(NUM_ENTRIES - 1, 64'd100);
      check_value(NUM_ENTRIES - 1, 64'd150);
      check_value(NUM_ENTRIES - 1, 64'd200);
      check_value(NUM_ENTRIES - 1, 64'd99);
      check_value(NUM_ENTRIES - 1, 64'd201);
      check_value(NUM_ENTRIES - 1, 64'd101);

      // inverted limits
      define_entry(5, 16'd0, 64'd300, 64'd100);
      send_command(CMD_ENABLE, 5);
      check_value(5, 64'd200);

      // extreme limits, intervals and event ids
      w               = random_word();
      w.cmd           = CMD_DEFINE;
      w.index         = 16'd1;
      w.interval      = 16'hFFFF;
      w.low_limit     = '1;
      w.high_limit    = '1;
      w.low_event_id  = 16'hFFFF;
      w.high_event_id = 16'hFFFF;
      send_word(w);
      send_command(CMD_ENABLE, 1);
      check_value(1, 64'd0);
      w               = random_word();
      w.cmd           = CMD_DEFINE;
      w.index         = 16'd2;
      w.interval      = 16'd0;
      w.low_limit     = '0;
      w.high_limit    = '1;
      w.low_event_id  = 16'h0000;
      w.high_event_id = 16'h0000;
      send_word(w);
      send_command(CMD_ENABLE, 2);
      check_value(2, '1);
      check_value(2, 64'd0);

      // disabled entry keeps its state
      send_command(CMD_DISABLE, NUM_ENTRIES - 1);
      check_value(NUM_ENTRIES - 1, 64'd250);

      wait_for_results();

      // Random part: define, enable, then checks around the limits,
      // with stray commands mixed in
      next_drain = words_sent + 250;
      while (words_sent < TARGET_WORDS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         idx  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_ENTRIES - 1)
                                            : $urandom_range(0, 7);
         ivl  = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
         lo   = {$urandom, $urandom};
         span = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, 40));
         hi   = lo + span;
         if ($urandom_range(0, 9) == 0)
            {lo, hi} = {hi, lo};
         // now and then the define or the enable is left out
         if ($urandom_range(0, 9) != 0)
            define_entry(idx, ivl, lo, hi);
         if ($urandom_range(0, 9) != 0)
            send_command(CMD_ENABLE, idx);
         repeat ($urandom_range(3, 14)) begin
            if ($urandom_range(0, 7) == 0) begin
               w = random_word();
               case ($urandom_range(0, 2))
                  0: w.index = 16'(idx);
                  1: w.index = 16'($urandom_range(0, 7));
                  default: ;   // keep the full random index
               endcase
               send_word(w);
            end else begin
               case ($urandom_range(0, 7))
                  0: v = lo - 1;
                  1: v = lo;
                  2: v = lo + 1;
                  3: v = hi - 1;
                  4: v = hi;
                  5: v = hi + 1;
                  6: v = lo + (hi - lo) / 2;
                  default: v = {$urandom, $urandom};
               endcase
               check_value(idx, v);
            end
         end
         if (words_sent >= next_drain) begin
            wait_for_results();
            next_drain = words_sent + 250;
         end
      end

      no_idle = 1'b0;
      wait_for_results();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS parameter_limit_monitor");
      end else begin
         $display("FAIL parameter_limit_monitor");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/plm_pkg.sv
rtl/plm_ram.sv
rtl/plm_update.sv
rtl/parameter_limit_monitor.sv
test/limit_monitor_checker.sv
test/tb_parameter_limit_monitor.sv
